// ----- design/ltm_pkg.sv -----
// ltm_pkg: types, constants and digit/code helpers for the loser tree merge.
// Used by ltm_match and loser_tree_merge_ovc_top; no dependencies.
`default_nettype none
package ltm_pkg;

	localparam int MAX_RUNS   = 16;
	localparam int KEY_DIGITS = 8;
	localparam int KEY_W      = 4 * KEY_DIGITS;
	localparam int RUN_W      = 4;
	localparam int CODE_W     = 17;
	localparam int OFF_W      = $clog2(KEY_DIGITS + 1);
	localparam int NODE_AW    = $clog2(MAX_RUNS);
	localparam int K_W        = NODE_AW + 1;
	localparam int TREE_AW    = NODE_AW + 1;
	localparam int CODE_HI    = 10000;
	localparam int CODE_LO    = 10;
	localparam int CNT_W      = 32;
	localparam int CFG_W      = 5;

	localparam logic MODE_LOAD = 1'b0;
	localparam logic MODE_NEXT = 1'b1;

	typedef struct packed {
		logic [KEY_W-1:0]  key;
		logic [RUN_W-1:0]  run;
		logic [CODE_W-1:0] code;
		logic              fence;
		logic              coded;
	} entry_t;

	localparam int ENTRY_W = $bits(entry_t);
	localparam int NODE_W  = ENTRY_W - 1;

	typedef struct packed {
		entry_t win_e;
		entry_t lose_e;
		logic   win;
		logic   avoided;
	} match_res_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_BRD,
		S_BCMP,
		S_RCMP,
		S_OUT
	} state_t;

	function automatic logic [3:0] digit_at(input logic [KEY_W-1:0] k, input logic [OFF_W-1:0] off);
		int sh;
		sh = 4 * (KEY_DIGITS - 1 - int'(off));
		if (int'(off) >= KEY_DIGITS)
			return 4'd0;
		return k[sh +: 4];
	endfunction

	// first digit position where a and b differ, KEY_DIGITS when equal
	function automatic logic [OFF_W-1:0] first_diff(input logic [KEY_W-1:0] a,
			input logic [KEY_W-1:0] b);
		logic [OFF_W-1:0] off;
		off = OFF_W'(KEY_DIGITS);
		for (int i = KEY_DIGITS - 1; i >= 0; i--) begin
			if (a[4*(KEY_DIGITS-1-i) +: 4] != b[4*(KEY_DIGITS-1-i) +: 4])
				off = OFF_W'(i);
		end
		return off;
	endfunction

	function automatic logic [CODE_W-1:0] code_at(input logic [KEY_W-1:0] k,
			input logic [OFF_W-1:0] off);
		if (int'(off) >= KEY_DIGITS)
			return '0;
		return CODE_W'((KEY_DIGITS - int'(off)) * CODE_HI + int'(off) * CODE_LO)
			+ CODE_W'(digit_at(k, off));
	endfunction

	function automatic logic [NODE_W-1:0] node_pack(input entry_t e);
		return {e.key, e.run, e.code, e.fence};
	endfunction

	function automatic entry_t node_unpack(input logic [NODE_W-1:0] d);
		entry_t e;
		e.key   = d[NODE_W-1 -: KEY_W];
		e.run   = d[CODE_W+1 +: RUN_W];
		e.code  = d[1 +: CODE_W];
		e.fence = d[0];
		e.coded = 1'b1;
		return e;
	endfunction

endpackage
`default_nettype wire

// ----- design/ltm_ram.sv -----
// ltm_ram: simple dual-port RAM, one write and one registered read per cycle.
// Generic; no package dependency.
`default_nettype none
module ltm_ram #(
	parameter int AW = 4,
	parameter int DW = 8
) (
	input  wire logic          clk,
	input  wire logic          we,
	input  wire logic [AW-1:0] waddr,
	input  wire logic [DW-1:0] wdata,
	input  wire logic [AW-1:0] raddr,
	output logic      [DW-1:0] rdata
);

	logic [DW-1:0] mem [2**AW];

	always_ff @(posedge clk) begin
		if (we)
			mem[waddr] <= wdata;
	end

	always_ff @(posedge clk) begin
		rdata <= mem[raddr];
	end

endmodule
`default_nettype wire

// ----- design/ltm_match.sv -----
// ltm_match: one loser tree match with offset-value codes.
// Depends on ltm_pkg.
`default_nettype none
module ltm_match (
	input  ltm_pkg::entry_t     cand,
	input  ltm_pkg::entry_t     other,
	output ltm_pkg::match_res_t res
);
	import ltm_pkg::*;

	logic [OFF_W-1:0] off;
	logic             win;
	entry_t           loser;

	assign off = first_diff(cand.key, other.key);

	always_comb begin
		res.avoided = 1'b0;
		if (cand.fence || other.fence) begin
			win         = !cand.fence && other.fence;
			loser       = win ? other : cand;
			loser.code  = '0;
			loser.coded = 1'b1;
		end else if (cand.coded && other.coded && cand.code != other.code) begin
			res.avoided = 1'b1;
			win         = cand.code < other.code;
			loser       = win ? other : cand;
		end else begin
			// full digit compare, loser recoded against the winner
			win         = (int'(off) < KEY_DIGITS)
				&& (digit_at(cand.key, off) < digit_at(other.key, off));
			loser       = win ? other : cand;
			loser.code  = code_at(loser.key, off);
			loser.coded = 1'b1;
		end
		res.win    = win;
		res.win_e  = win ? cand : other;
		res.lose_e = loser;
	end

endmodule
`default_nettype wire

// ----- design/loser_tree_merge_ovc_top.sv -----
// loser_tree_merge_ovc_top: K-way merge through a loser tree with offset-value codes.
// Depends on ltm_pkg, ltm_ram and ltm_match.
//
//  channel  | handshake                | payload
//  ---------+--------------------------+---------------------------------------------
//  config   | num_runs_we              | num_runs_wdata[4:0]
//  input    | in_valid / in_stall      | mode, run_id, key, exhausted
//  output   | out_valid / out_stall    | winner_run, winner_key, winner_code,
//           |                          | done_res, avoided_count
//
// A load that fills no tree leaves the block idle. The last load builds the tree: each
// node match is a leaf buffer read, then a compare and write, over K-1 nodes, then output.
// A next transaction replays one leaf-to-root path: a node read issue, then one compare
// per level (node RAM read of the parent overlaps the compare), then output.
// In_stall is high whenever a transaction is in work.
// Reset clears control only; the node RAM and leaf buffer need no clearing pass,
// unloaded leaves are covered by per-leaf valid bits.
`default_nettype none
module loser_tree_merge_ovc_top (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          num_runs_we,
	input  wire logic [ltm_pkg::CFG_W-1:0]     num_runs_wdata,
	input  wire logic                          in_valid,
	output logic                               in_stall,
	input  wire logic                          mode,
	input  wire logic [ltm_pkg::RUN_W-1:0]     run_id,
	input  wire logic [ltm_pkg::KEY_W-1:0]     key,
	input  wire logic                          exhausted,
	output logic                               out_valid,
	input  wire logic                          out_stall,
	output logic [ltm_pkg::RUN_W-1:0]          winner_run,
	output logic [ltm_pkg::KEY_W-1:0]          winner_key,
	output logic [ltm_pkg::CODE_W-1:0]         winner_code,
	output logic                               done_res,
	output logic [ltm_pkg::CNT_W-1:0]          avoided_count
);
	import ltm_pkg::*;

	// control state
	state_t               state_q, state_n;
	logic [K_W-1:0]       k_q;
	logic [K_W-1:0]       loads_q, loads_n, lcnt;
	logic [MAX_RUNS-1:0]  leaf_vld_q, leaf_vld_n;
	logic [TREE_AW-1:0]   idx_q, idx_n;      // build: child index i, replay: node p
	entry_t               cand_q, cand_n;
	entry_t               win_q, win_n;
	logic [CNT_W-1:0]     avoid_q, avoid_n;
	logic                 out_valid_q, load_out;

	// output register
	logic [RUN_W-1:0]     out_run_q;
	logic [KEY_W-1:0]     out_key_q;
	logic [CODE_W-1:0]    out_code_q;
	logic                 out_done_q;
	logic [CNT_W-1:0]     out_cnt_q;

	// memories
	logic                 tb_we;
	logic [TREE_AW-1:0]   tb_waddr, tb_ra0, tb_ra1;
	logic [ENTRY_W-1:0]   tb_wdata, tb_rd0, tb_rd1;
	logic                 nd_we;
	logic [NODE_AW-1:0]   nd_waddr, nd_raddr;
	logic [NODE_W-1:0]    nd_wdata, nd_rd;

	entry_t               leaf_e, ta_e, tb_e, nd_e, m_cand, m_other;
	match_res_t           mres;
	logic [RUN_W-1:0]     rrun;
	logic [TREE_AW-1:0]   rp, i1;
	logic [CFG_W-1:0]     cfg_v;

	// tree slot t[i]: leaves live at {1,run}, internal winners at {0,i}
	function automatic logic [TREE_AW-1:0] taddr(input logic [TREE_AW-1:0] i,
			input logic [K_W-1:0] k);
		if (i >= k)
			return {1'b1, NODE_AW'(i - k)};
		return {1'b0, i[NODE_AW-1:0]};
	endfunction

	function automatic entry_t leaf_fix(input entry_t e, input logic [TREE_AW-1:0] i,
			input logic [K_W-1:0] k, input logic [MAX_RUNS-1:0] vld);
		if (i >= k && !vld[NODE_AW'(i - k)])
			return '0;   // never loaded: key 0, run 0, uncoded
		return e;
	endfunction

	// two copies give the two read ports of the tree buffer
	ltm_ram #(.AW(TREE_AW), .DW(ENTRY_W)) u_tbuf0 (
		.clk(clk), .we(tb_we), .waddr(tb_waddr), .wdata(tb_wdata),
		.raddr(tb_ra0), .rdata(tb_rd0)
	);
	ltm_ram #(.AW(TREE_AW), .DW(ENTRY_W)) u_tbuf1 (
		.clk(clk), .we(tb_we), .waddr(tb_waddr), .wdata(tb_wdata),
		.raddr(tb_ra1), .rdata(tb_rd1)
	);
	ltm_ram #(.AW(NODE_AW), .DW(NODE_W)) u_nodes (
		.clk(clk), .we(nd_we), .waddr(nd_waddr), .wdata(nd_wdata),
		.raddr(nd_raddr), .rdata(nd_rd)
	);

	assign i1      = idx_q - TREE_AW'(1);
	assign ta_e    = leaf_fix(entry_t'(tb_rd0), idx_q, k_q, leaf_vld_q);
	assign tb_e    = leaf_fix(entry_t'(tb_rd1), i1, k_q, leaf_vld_q);
	assign nd_e    = node_unpack(nd_rd);
	assign m_cand  = (state_q == S_RCMP) ? cand_q : ta_e;
	assign m_other = (state_q == S_RCMP) ? nd_e : tb_e;

	ltm_match u_match (.cand(m_cand), .other(m_other), .res(mres));

	// leaf coded against all zeros
	always_comb begin
		leaf_e.key   = key;
		leaf_e.run   = run_id;
		leaf_e.code  = exhausted ? '0 : code_at(key, first_diff(key, '0));
		leaf_e.fence = exhausted;
		leaf_e.coded = 1'b1;
	end

	assign rrun = ({1'b0, win_q.run} >= k_q) ? '0 : win_q.run;
	assign rp   = TREE_AW'((k_q + K_W'(rrun)) >> 1);
	assign lcnt = (loads_q >= k_q) ? '0 : loads_q;

	always_comb begin
		state_n    = state_q;
		idx_n      = idx_q;
		cand_n     = cand_q;
		win_n      = win_q;
		loads_n    = loads_q;
		leaf_vld_n = leaf_vld_q;
		avoid_n    = avoid_q;
		load_out   = 1'b0;
		tb_we      = 1'b0;
		tb_waddr   = '0;
		tb_wdata   = '0;
		tb_ra0     = '0;
		tb_ra1     = '0;
		nd_we      = 1'b0;
		nd_waddr   = '0;
		nd_wdata   = '0;
		nd_raddr   = '0;
		if ((state_q == S_BCMP || state_q == S_RCMP) && mres.avoided && avoid_q != '1)
			avoid_n = avoid_q + CNT_W'(1);
		unique case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					if (mode == MODE_LOAD) begin
						if ({1'b0, run_id} < k_q) begin
							tb_we               = 1'b1;
							tb_waddr            = {1'b1, run_id};
							tb_wdata            = leaf_e;
							leaf_vld_n[run_id] = 1'b1;
							loads_n             = lcnt + K_W'(1);
							if (loads_n == k_q) begin
								idx_n   = TREE_AW'({k_q, 1'b0} - 6'd1);
								state_n = S_BRD;
							end
						end
					end else if (loads_q >= k_q) begin
						cand_n.key   = key;
						cand_n.run   = rrun;
						cand_n.code  = '0;
						cand_n.fence = exhausted;
						cand_n.coded = exhausted;
						nd_raddr     = rp[NODE_AW-1:0];
						idx_n        = rp;
						state_n      = S_RCMP;
					end
				end
			end
			S_BRD: begin
				tb_ra0  = taddr(idx_q, k_q);
				tb_ra1  = taddr(i1, k_q);
				state_n = S_BCMP;
			end
			S_BCMP: begin
				nd_we    = 1'b1;
				nd_waddr = idx_q[TREE_AW-1:1];
				nd_wdata = node_pack(mres.lose_e);
				tb_we    = 1'b1;
				tb_waddr = {1'b0, idx_q[TREE_AW-1:1]};
				tb_wdata = mres.win_e;
				if (idx_q[TREE_AW-1:1] == NODE_AW'(1)) begin
					win_n   = mres.win_e;
					state_n = S_OUT;
				end else begin
					idx_n   = idx_q - TREE_AW'(2);
					state_n = S_BRD;
				end
			end
			S_RCMP: begin
				nd_we    = 1'b1;
				nd_waddr = idx_q[NODE_AW-1:0];
				nd_wdata = node_pack(mres.lose_e);
				cand_n   = mres.win_e;
				idx_n    = idx_q >> 1;
				nd_raddr = idx_q[TREE_AW-1:1];   // parent read overlaps this compare
				if (idx_q[TREE_AW-1:1] == '0) begin
					win_n   = mres.win_e;
					state_n = S_OUT;
				end
			end
			S_OUT: begin
				if (!out_valid_q || !out_stall) begin
					load_out = 1'b1;
					state_n  = S_IDLE;
				end
			end
			default: state_n = S_IDLE;
		endcase
	end

	always_comb begin
		cfg_v = num_runs_wdata;
		if (cfg_v < CFG_W'(2))
			cfg_v = CFG_W'(2);
		if (cfg_v > CFG_W'(MAX_RUNS))
			cfg_v = CFG_W'(MAX_RUNS);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			k_q         <= K_W'(MAX_RUNS);
			loads_q     <= '0;
			leaf_vld_q  <= '0;
			win_q       <= '0;
			avoid_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q    <= state_n;
			leaf_vld_q <= leaf_vld_n;
			win_q      <= win_n;
			avoid_q    <= avoid_n;
			// a run count write restarts the load phase
			loads_q    <= num_runs_we ? '0 : loads_n;
			if (num_runs_we)
				k_q <= K_W'(cfg_v);
			if (load_out)
				out_valid_q <= 1'b1;
			else if (!out_stall)
				out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		idx_q  <= idx_n;
		cand_q <= cand_n;
		if (load_out) begin
			out_run_q  <= win_q.run;
			out_key_q  <= win_q.key;
			out_code_q <= (win_q.coded && !win_q.fence) ? win_q.code : '0;
			out_done_q <= win_q.fence;
			out_cnt_q  <= avoid_q;
		end
	end

	assign in_stall      = (state_q != S_IDLE);
	assign out_valid     = out_valid_q;
	assign winner_run    = out_run_q;
	assign winner_key    = out_key_q;
	assign winner_code   = out_code_q;
	assign done_res      = out_done_q;
	assign avoided_count = out_cnt_q;

	// load counter never runs past the run count
	a_loads_le_k: assert property (@(posedge clk) disable iff (!arst_n)
		loads_q <= k_q) else $error("load count above run count");

	// run count stays clamped
	a_k_range: assert property (@(posedge clk) disable iff (!arst_n)
		k_q >= K_W'(2) && k_q <= K_W'(MAX_RUNS)) else $error("run count out of range");

	// saturating counter never goes backward
	a_avoid_mono: assert property (@(posedge clk) disable iff (!arst_n)
		avoid_q >= $past(avoid_q)) else $error("avoided count decreased");

	// replay never addresses the unused node zero
	a_replay_node: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_RCMP |-> idx_q != '0) else $error("replay at node zero");

endmodule
`default_nettype wire

// ----- sim/tb_top.sv -----
// tb_top: self-checking testbench for loser_tree_merge_ovc_top.
// Holds its own loser-tree predictor; depends on ltm_pkg and the design files.
`timescale 1ns / 100ps
`default_nettype none
module tb_top;
	import ltm_pkg::*;

	// A tree entry in the predictor: key, run, code and flags.
	typedef struct {
		logic [31:0] key;
		logic [3:0]  run;
		logic [16:0] code;
		bit          fence;
		bit          coded;
	} ent_t;

	// One winner transaction as the block shows it.
	typedef struct {
		logic [3:0]  run;
		logic [31:0] key;
		logic [16:0] code;
		logic        done;
		logic [31:0] avoided;
	} win_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic num_runs_we = 1'b0;
	logic [4:0] num_runs_wdata = '0;
	logic in_valid = 1'b0;
	logic in_stall;
	logic mode = 1'b0;
	logic [3:0] run_id = '0;
	logic [31:0] key = '0;
	logic exhausted = 1'b0;
	logic out_valid;
	logic out_stall = 1'b0;
	logic [3:0] winner_run;
	logic [31:0] winner_key;
	logic [16:0] winner_code;
	logic done_res;
	logic [31:0] avoided_count;

	loser_tree_merge_ovc_top dut (
		.clk(clk), .arst_n(arst_n),
		.num_runs_we(num_runs_we), .num_runs_wdata(num_runs_wdata),
		.in_valid(in_valid), .in_stall(in_stall),
		.mode(mode), .run_id(run_id), .key(key), .exhausted(exhausted),
		.out_valid(out_valid), .out_stall(out_stall),
		.winner_run(winner_run), .winner_key(winner_key), .winner_code(winner_code),
		.done_res(done_res), .avoided_count(avoided_count)
	);

	always #5 clk = ~clk;

	// ---- predictor state ----
	int unsigned k_runs = 16;
	ent_t nodes[16];
	ent_t leaves[16];
	ent_t cur_win;
	int unsigned loads_cnt = 0;
	logic [31:0] avoid_tot = '0;

	win_t winners_due[$];
	int errors = 0;
	int send_idle_pct = 0;  // sender gap probability
	int recv_stall_pct = 0; // receiver stall probability

	function automatic logic [3:0] dig(logic [31:0] k, int i);
		return k[4*(7-i) +: 4];
	endfunction

	function automatic logic [16:0] ovc(logic [31:0] k, int off);
		if (off >= 8)
			return '0;
		return 17'((8 - off) * 10000 + off * 10 + dig(k, off));
	endfunction

	// Returns 1 when a beats b; unless the codes decide, the loser's code gets refreshed.
	function automatic bit play(ref ent_t a, ref ent_t b);
		int off;
		bit w;
		if (a.fence || b.fence) begin
			w = !a.fence && b.fence;
			if (w) begin b.code = '0; b.coded = 1; end
			else begin a.code = '0; a.coded = 1; end
			return w;
		end
		if (a.coded && b.coded && a.code != b.code) begin
			if (avoid_tot != 32'hFFFF_FFFF)
				avoid_tot++;
			return a.code < b.code;
		end
		off = 0;
		while (off < 8 && dig(a.key, off) == dig(b.key, off))
			off++;
		w = off < 8 && dig(a.key, off) < dig(b.key, off);
		if (w) begin b.code = ovc(b.key, off); b.coded = 1; end
		else begin a.code = ovc(a.key, off); a.coded = 1; end
		return w;
	endfunction

	function automatic void push_winner();
		win_t w;
		w.run = cur_win.run;
		w.key = cur_win.key;
		w.code = (cur_win.coded && !cur_win.fence) ? cur_win.code : '0;
		w.done = cur_win.fence;
		w.avoided = avoid_tot;
		winners_due = {winners_due, w};
	endfunction

	function automatic void build();
		ent_t t[32];
		ent_t x, y;
		int i;
		for (i = 0; i < 32; i++)
			t[i] = '{default: 0};
		for (i = 0; i < int'(k_runs); i++)
			t[k_runs + i] = leaves[i];
		for (i = 2 * k_runs - 1; i >= 2; i -= 2) begin
			x = t[i];
			y = t[i-1];
			if (play(x, y)) begin
				nodes[i>>1] = y;
				nodes[i>>1].coded = 1;
				t[i>>1] = x;
			end else begin
				nodes[i>>1] = x;
				nodes[i>>1].coded = 1;
				t[i>>1] = y;
			end
		end
		cur_win = t[1];
	endfunction

	// Predicts what one accepted input transaction yields.
	function automatic void predict_merge(logic m, logic [3:0] rid, logic [31:0] kk, logic fz);
		ent_t c, s, tmp;
		int off;
		int unsigned p;
		c.key = kk;
		c.fence = fz;
		if (m == MODE_LOAD) begin
			if (rid >= k_runs)
				return;
			if (loads_cnt >= k_runs)
				loads_cnt = 0;
			off = 0;
			while (off < 8 && dig(kk, off) == 0)
				off++;
			c.run = rid;
			c.code = fz ? '0 : ovc(kk, off);
			c.coded = 1;
			leaves[rid] = c;
			loads_cnt++;
			if (loads_cnt < k_runs)
				return;
			build();
			push_winner();
			return;
		end
		if (loads_cnt < k_runs)
			return;
		c.run = cur_win.run;
		if (c.run >= k_runs)
			c.run = 0;
		c.code = '0;
		c.coded = fz;
		p = (k_runs + c.run) >> 1;
		while (p >= 1) begin
			s = nodes[p];
			s.coded = 1;
			if (!play(c, s)) begin
				tmp = s;
				s = c;
				c = tmp;
			end
			nodes[p] = s;
			p >>= 1;
		end
		cur_win = c;
		push_winner();
	endfunction

	// ---- driving ----
	// Valid stays high into the next transaction; drain() drops it when sending stops.
	task automatic send_item(logic m, logic [3:0] rid, logic [31:0] kk, logic fz);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		mode <= m;
		run_id <= rid;
		key <= kk;
		exhausted <= fz;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		predict_merge(m, rid, kk, fz);
		@(negedge clk);
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		while (winners_due.size() != 0)
			@(negedge clk);
		repeat (60) @(negedge clk);
	endtask

	task automatic set_runs(logic [4:0] v);
		int unsigned c;
		drain();
		num_runs_we <= 1'b1;
		num_runs_wdata <= v;
		@(negedge clk);
		num_runs_we <= 1'b0;
		c = v;
		if (c < 2) c = 2;
		if (c > 16) c = 16;
		k_runs = c;
		loads_cnt = 0;
	endtask

	// Random key; sometimes shares prefixes to force equal codes.
	function automatic logic [31:0] rand_key();
		logic [31:0] r;
		case ($urandom_range(3))
			0: r = $urandom();
			1: r = $urandom() & 32'h0000_0FFF;
			2: r = 32'h1234_0000 | ($urandom() & 32'h0000_00FF);
			default: r = {8{4'($urandom_range(9))}} ^ ($urandom() & 32'h0000_0003);
		endcase
		return r;
	endfunction

	task automatic load_all();
		for (int r = 0; r < int'(k_runs); r++)
			send_item(MODE_LOAD, 4'(r), rand_key(), $urandom_range(15) == 0);
	endtask

	// ---- checking on the output channel ----
	always @(negedge clk)
		out_stall <= ($urandom_range(99) < recv_stall_pct);

	always @(posedge clk) begin
		win_t w;
		if (arst_n && out_valid && !out_stall) begin
			if (winners_due.size() == 0) begin
				$error("winner transaction with nothing expected");
				errors++;
			end else begin
				w = winners_due.pop_front();
				if (winner_run !== w.run) begin
					$error("winner_run exp %0h got %0h", w.run, winner_run); errors++;
				end
				if (winner_key !== w.key) begin
					$error("winner_key exp %0h got %0h", w.key, winner_key); errors++;
				end
				if (winner_code !== w.code) begin
					$error("winner_code exp %0d got %0d", w.code, winner_code); errors++;
				end
				if (done_res !== w.done) begin
					$error("done_res exp %0d got %0d", w.done, done_res); errors++;
				end
				if (avoided_count !== w.avoided) begin
					$error("avoided_count exp %0d got %0d", w.avoided, avoided_count);
					errors++;
				end
			end
		end
	end

	// ---- tests ----
	task automatic test_directed();
		// default sixteen runs: extreme keys, an unused leaf path
		send_item(MODE_NEXT, 4'd0, 32'h1, 1'b0);      // next before build: ignored
		send_item(MODE_LOAD, 4'd0, 32'hFFFF_FFFF, 1'b0);
		send_item(MODE_LOAD, 4'd0, 32'h0, 1'b0);       // repeated load still counts
		for (int r = 2; r < 16; r++)
			send_item(MODE_LOAD, 4'(r), 32'h0000_0100 * r, r == 15);
		send_item(MODE_NEXT, 4'd9, 32'h0000_0000, 1'b0);
		send_item(MODE_NEXT, 4'd0, 32'h0000_0005, 1'b0);
		set_runs(5'd0);                                // clamps to two
		send_item(MODE_LOAD, 4'd15, 32'h1, 1'b0);      // out of range: ignored
		send_item(MODE_LOAD, 4'd0, 32'h5555_5555, 1'b1);
		send_item(MODE_LOAD, 4'd1, 32'hAAAA_AAAA, 1'b1);
		send_item(MODE_NEXT, 4'd0, 32'hDEAD_BEEF, 1'b1); // next after done
		send_item(MODE_NEXT, 4'd0, 32'h0, 1'b0);
		send_item(MODE_LOAD, 4'd1, 32'h9999_9999, 1'b0); // reload mid merge
		send_item(MODE_LOAD, 4'd0, 32'h9999_9999, 1'b0); // equal keys tie
		set_runs(5'd31);                               // clamps to sixteen
	endtask

	task automatic test_random(int n);
		int sent = 0;
		logic [4:0] kv;
		while (sent < n) begin
			kv = 5'($urandom_range(31));
			if ($urandom_range(3) == 0) kv = 5'($urandom_range(2, 4));
			set_runs(kv);
			load_all();
			sent += k_runs;
			repeat ($urandom_range(10, 40)) begin
				if ($urandom_range(19) == 0)
					send_item(MODE_LOAD, 4'($urandom()), rand_key(),
						1'($urandom_range(1)));
				else
					send_item(MODE_NEXT, 4'($urandom()), rand_key(),
						$urandom_range(5) == 0);
				sent++;
			end
		end
	endtask

	task automatic test_pause();
		drain(); // sender holds off until every winner has come
		send_item(MODE_NEXT, 4'd0, $urandom(), 1'b0);
	endtask

	initial begin
		repeat (2) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);
		test_directed();
		send_idle_pct = 0;  recv_stall_pct = 0;  test_random(350);
		send_idle_pct = 67; recv_stall_pct = 0;  test_random(350);
		test_pause();
		send_idle_pct = 0;  recv_stall_pct = 67; test_random(350);
		send_idle_pct = 7;  recv_stall_pct = 7;  test_random(350);
		drain();
		if (errors == 0)
			$display("loser_tree_merge_ovc_top regression: pass");
		else
			$display("loser_tree_merge_ovc_top regression: fail");
		$finish;
	end

	initial begin
		#5ms;
		$display("loser_tree_merge_ovc_top regression: fail");
		$finish;
	end
endmodule
`default_nettype wire

// ----- sim.f -----
design/ltm_pkg.sv
design/ltm_ram.sv
design/ltm_match.sv
design/loser_tree_merge_ovc_top.sv
sim/tb_top.sv
